[sv/rmst_pkg.sv]
// shared constants for the range minimum segment tree
// field widths, stream packing and the sentinel that every node resets to
package rmst_pkg;

  localparam int unsigned LeavesDefault = 1024;
  localparam int unsigned IdxW          = 10;
  localparam int unsigned DataW         = 32;

  // input tdata: left_index, right_index, value, zero fill to whole bytes
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 32;

  localparam int unsigned LeftLsb  = 0;
  localparam int unsigned RightLsb = LeftLsb + IdxW;
  localparam int unsigned ValueLsb = RightLsb + IdxW;

  localparam logic [DataW-1:0] Sentinel = 32'd2000000000;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

endpackage

[sv/rmst_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module rmst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/range_min_segment_tree.sv]
// range minimum segment tree with point update, top level
// depends on rmst_pkg and rmst_ram
//
// s_axis carries one item per transfer; tuser is the kind (0 update,
// 1 query), tdata holds left_index, right_index and value.
// m_axis returns one result per item; tdata is min_value (query minimum,
// or the written value on update), tuser is range_error.
// one item at a time through a single node ram with registered read and
// one shared signed compare unit; s_axis_tready_o is high only while idle.
// an update writes the leaf, then does one sibling read and one parent write
// per tree level; a query does at most one read for each end of the range
// per tree level; an index error goes straight to the result.
// after rst_ni releases, a clearing pass writes the sentinel 2000000000 to
// every node, with s_axis_tready_o low.
// when the receiver stalls the result waits in the output register; the
// next item may be taken and worked on, but its result holds until the
// receiver takes the previous one.
module range_min_segment_tree #(
  parameter int unsigned LEAVES = rmst_pkg::LeavesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // left_index [9:0], right_index [19:10], value [51:20], zero [55:52]
  input  logic [rmst_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // kind
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // min_value [31:0]
  output logic [rmst_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // range_error
  output logic                           m_axis_tuser_o
);

  import rmst_pkg::*;

  localparam int unsigned Nodes = 2 * LEAVES;
  localparam int unsigned NW    = $clog2(Nodes);
  localparam int unsigned PW    = NW + 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_WR,
    ST_UPD_RD,
    ST_UPD_MIN,
    ST_QRY_A,
    ST_QRY_AW,
    ST_QRY_B,
    ST_QRY_BW,
    ST_QRY_SH,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [NW-1:0]       clr_q;
  logic [NW-1:0]       k_q;
  logic [PW-1:0]       a_q, b_q;
  logic [DataW-1:0]    carry_q;
  logic [DataW-1:0]    best_q;
  logic                have_q;
  logic [DataW-1:0]    res_q;
  logic                err_q;
  logic                m_valid_q;
  logic [DataW-1:0]    m_data_q;
  logic                m_err_q;

  logic [IdxW-1:0]     left_idx, right_idx;
  logic [DataW-1:0]    in_value;
  logic                in_fire;

  logic                mem_we;
  logic [NW-1:0]       mem_waddr, mem_raddr;
  logic [DataW-1:0]    mem_wdata, mem_rdata;

  logic [DataW-1:0]    cmp_a, cmp_b, cmp_min;
  logic [PW-1:0]       b_dec;

  assign left_idx  = s_axis_tdata_i[LeftLsb +: IdxW];
  assign right_idx = s_axis_tdata_i[RightLsb +: IdxW];
  assign in_value  = s_axis_tdata_i[ValueLsb +: DataW];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign b_dec           = b_q - PW'(1);

  // shared signed minimum, first operand wins a tie
  always_comb begin
    cmp_a = best_q;
    cmp_b = mem_rdata;
    if (state_q == ST_UPD_MIN) begin
      cmp_a = carry_q;
    end
    cmp_min = ($signed(cmp_a) <= $signed(cmp_b)) ? cmp_a : cmp_b;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_q;
    mem_wdata = carry_q;
    mem_raddr = k_q ^ NW'(1);
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = Sentinel;
      end
      ST_UPD_WR: begin
        mem_we = 1'b1;
      end
      ST_UPD_MIN: begin
        mem_we    = 1'b1;
        mem_waddr = k_q >> 1;
        mem_wdata = cmp_min;
      end
      ST_QRY_A: begin
        mem_raddr = a_q[NW-1:0];
      end
      ST_QRY_B: begin
        mem_raddr = b_dec[NW-1:0];
      end
      default: begin
      end
    endcase
  end

  rmst_ram #(
    .Width(DataW),
    .Depth(Nodes)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i && state_q != ST_DONE) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + NW'(1);
          if (clr_q == NW'(Nodes - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            have_q <= 1'b0;
            best_q <= '0;
            if (kind_e'(s_axis_tuser_i) == KIND_UPDATE) begin
              res_q   <= in_value;
              carry_q <= in_value;
              k_q     <= NW'(LEAVES) + NW'(left_idx);
              if (32'(left_idx) < 32'(LEAVES)) begin
                err_q   <= 1'b0;
                state_q <= ST_UPD_WR;
              end else begin
                err_q   <= 1'b1;
                state_q <= ST_DONE;
              end
            end else begin
              a_q <= PW'(LEAVES) + PW'(left_idx);
              b_q <= PW'(LEAVES) + PW'(right_idx) + PW'(1);
              if (left_idx > right_idx || 32'(right_idx) >= 32'(LEAVES)) begin
                err_q   <= 1'b1;
                res_q   <= '0;
                state_q <= ST_DONE;
              end else begin
                err_q   <= 1'b0;
                state_q <= ST_QRY_A;
              end
            end
          end
        end
        ST_UPD_WR: begin
          state_q <= ST_UPD_RD;
        end
        ST_UPD_RD: begin
          if (k_q == NW'(1)) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_UPD_MIN;
          end
        end
        ST_UPD_MIN: begin
          carry_q <= cmp_min;
          k_q     <= k_q >> 1;
          state_q <= ST_UPD_RD;
        end
        ST_QRY_A: begin
          if (a_q >= b_q) begin
            res_q   <= best_q;
            state_q <= ST_DONE;
          end else if (a_q[0]) begin
            a_q     <= a_q + PW'(1);
            state_q <= ST_QRY_AW;
          end else begin
            state_q <= ST_QRY_B;
          end
        end
        ST_QRY_AW: begin
          best_q  <= have_q ? cmp_min : mem_rdata;
          have_q  <= 1'b1;
          state_q <= ST_QRY_B;
        end
        ST_QRY_B: begin
          if (b_q[0]) begin
            b_q     <= b_dec;
            state_q <= ST_QRY_BW;
          end else begin
            state_q <= ST_QRY_SH;
          end
        end
        ST_QRY_BW: begin
          best_q  <= have_q ? cmp_min : mem_rdata;
          have_q  <= 1'b1;
          state_q <= ST_QRY_SH;
        end
        ST_QRY_SH: begin
          a_q     <= a_q >> 1;
          b_q     <= b_q >> 1;
          state_q <= ST_QRY_A;
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_q;
            m_err_q   <= err_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_err_q;

endmodule
